// ===== rtl/sstf_disk_schedule_movement_defines.svh =====
// Assertion macros shared by the disk scheduler RTL.
// Included by the top level; depends on nothing else.
`ifndef SSTF_DISK_SCHEDULE_MOVEMENT_DEFINES_SVH
`define SSTF_DISK_SCHEDULE_MOVEMENT_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define SDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define SDS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/sds_pkg.sv =====
// Shared types and constants for the disk scheduler.
// No dependencies.
`default_nettype none
package sds_pkg;
    localparam int unsigned CYL_W  = 13;
    localparam int unsigned MOVE_W = 23;
    localparam logic [MOVE_W-1:0] MOVE_MAX = {MOVE_W{1'b1}};

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // store incoming request
        logic ins_step;  // one shift step of the insertion
        logic ins_done;  // insertion finished, write item
        logic best_step;
        logic walk_init;
        logic walk_step;
        logic batch_clr;
        logic rd_ins;    // read the entry below the insertion point
        logic rd_best;   // read the entry under the search index
        logic rd_walk;   // read the next low or high neighbor
    } t_cmd;

    typedef struct packed {
        logic ins_fin;   // insertion position found
        logic cnt_zero;
        logic best_fin;
        logic walk_fin;
        logic full;
    } t_sts;
endpackage
`default_nettype wire

// ===== rtl/sstf_disk_schedule_movement.sv =====
// Shortest-seek-time-first disk scheduler: total head movement per batch.
// Loading: each request is inserted in order, shifting up each stored entry it passes;
// a request that arrives while the store is full is dropped and sets overflow.
// On the last item: nearest search over the store, then the outward walk.
// Result waits in an output register until taken; one batch at a time.
// Reset (synchronous, active low) clears count, overflow flag and head start.
`default_nettype none
module sstf_disk_schedule_movement #(
    parameter int unsigned MAX_REQUESTS = 1024,
    parameter int unsigned CYLINDERS    = 8192
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // [12:0] request_cylinder
    input  wire logic        s_axis_tlast,  // is_last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // [22:0] total_movement
    output logic             m_axis_tuser,  // overflowed
    input  wire logic        i_cfg_we,
    input  wire logic [12:0] i_cfg_data     // head_start
);
    import sds_pkg::*;
    `include "sstf_disk_schedule_movement_defines.svh"

    t_cmd cmd;
    t_sts sts;
    logic in_acc, out_acc;
    logic [MOVE_W-1:0] total;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    sds_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_acc(in_acc), .i_in_last(s_axis_tlast),
        .i_out_acc(out_acc), .i_sts(sts), .o_cmd(cmd), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid)
    );

    sds_datapath #(.MAX_REQUESTS(MAX_REQUESTS), .CYLINDERS(CYLINDERS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_req(s_axis_tdata[CYL_W-1:0]),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data), .o_sts(sts), .o_total(total),
        .o_ovf(m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, total};

    `SDS_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)
    `SDS_ASSERT_NXT(a_out_clear, i_clk, i_rst_n, out_acc, s_axis_tready)
    `SDS_ASSERT_IMP(a_cmd_excl, i_clk, i_rst_n, cmd.load, !cmd.walk_step && !cmd.ins_step)
endmodule
`default_nettype wire

// ===== rtl/sds_ctrl.sv =====
// Controller state machine for the disk scheduler.
// Depends on sds_pkg.
`default_nettype none
module sds_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_acc,
    input  wire logic          i_in_last,
    input  wire logic          i_out_acc,
    input  wire sds_pkg::t_sts i_sts,
    output sds_pkg::t_cmd      o_cmd,
    output logic               o_in_ready,
    output logic               o_out_valid
);
    import sds_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_INS_RD, S_INS_CHK, S_BEST_RD, S_BEST_CHK,
        S_WALK_RD, S_WALK_CHK, S_OUT
    } t_state;

    t_state r_state;
    logic   r_last;

    always_comb begin
        o_cmd = '0;
        o_in_ready = (r_state == S_IDLE);
        o_out_valid = (r_state == S_OUT);
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_acc;
            end
            S_INS_RD: begin
                o_cmd.rd_ins = 1'b1;
            end
            S_INS_CHK: begin
                if (i_sts.ins_fin) begin
                    o_cmd.ins_done = 1'b1;
                end else begin
                    o_cmd.ins_step = 1'b1;
                end
            end
            S_BEST_RD: begin
                o_cmd.rd_best = !i_sts.cnt_zero;
            end
            S_BEST_CHK: begin
                o_cmd.best_step = 1'b1;
                if (i_sts.best_fin) begin
                    o_cmd.walk_init = 1'b1;
                end
            end
            S_WALK_RD: begin
                o_cmd.rd_walk = !i_sts.walk_fin;
            end
            S_WALK_CHK: begin
                o_cmd.walk_step = 1'b1;
            end
            S_OUT: begin
                o_cmd.batch_clr = i_out_acc;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_acc) begin
                        r_last  <= i_in_last;
                        r_state <= i_sts.full ? (i_in_last ? S_BEST_RD : S_IDLE) : S_INS_RD;
                    end
                end
                S_INS_RD: r_state <= S_INS_CHK;
                S_INS_CHK: begin
                    if (i_sts.ins_fin) begin
                        r_state <= r_last ? S_BEST_RD : S_IDLE;
                    end else begin
                        r_state <= S_INS_RD;
                    end
                end
                S_BEST_RD: begin
                    r_state <= i_sts.cnt_zero ? S_OUT : S_BEST_CHK;
                end
                S_BEST_CHK: begin
                    r_state <= i_sts.best_fin ? S_WALK_RD : S_BEST_RD;
                end
                S_WALK_RD: begin
                    r_state <= i_sts.walk_fin ? S_OUT : S_WALK_CHK;
                end
                S_WALK_CHK: r_state <= S_WALK_RD;
                S_OUT: begin
                    if (i_out_acc) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/sds_datapath.sv =====
// Datapath of the disk scheduler: sorted request memory, insertion,
// nearest search and outward walk. Depends on sds_pkg.
`default_nettype none
module sds_datapath #(
    parameter int unsigned MAX_REQUESTS = 1024,
    parameter int unsigned CYLINDERS    = 8192
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire sds_pkg::t_cmd              i_cmd,
    input  wire logic [sds_pkg::CYL_W-1:0]  i_req,
    input  wire logic                       i_cfg_we,
    input  wire logic [sds_pkg::CYL_W-1:0]  i_cfg_data,
    output sds_pkg::t_sts                   o_sts,
    output logic [sds_pkg::MOVE_W-1:0]      o_total,
    output logic                            o_ovf
);
    import sds_pkg::*;

    localparam int unsigned AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int unsigned CW = $clog2(MAX_REQUESTS + 1);
    localparam logic [CYL_W-1:0] CYL_TOP =
        (CYLINDERS >= (1 << CYL_W)) ? {CYL_W{1'b1}} : CYL_W'(CYLINDERS - 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_REQUESTS);

    logic [CYL_W-1:0] r_mem [MAX_REQUESTS];
    logic [CYL_W-1:0] r_rdata;

    logic [CW-1:0]    r_cnt;
    logic             r_ovf;
    logic [CYL_W-1:0] r_head;
    logic [CYL_W-1:0] r_new;
    logic [CW-1:0]    r_pos;
    logic [CW-1:0]    r_idx;
    logic [CYL_W-1:0] r_bdist;
    logic [CW-1:0]    r_lo;   // entries left below
    logic [CW-1:0]    r_hi;   // next index above
    logic [CYL_W-1:0] r_cur;
    logic [CYL_W-1:0] r_lval;
    logic             r_lok;
    logic [MOVE_W:0]  r_total;

    function automatic logic [CYL_W-1:0] f_dist(logic [CYL_W-1:0] a, logic [CYL_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [CYL_W-1:0] f_clamp(logic [CYL_W-1:0] v);
        return (v > CYL_TOP) ? CYL_TOP : v;
    endfunction

    logic [CW-1:0] rd_addr;
    logic          rd_en;
    logic          lo_avail, hi_avail;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [CYL_W-1:0] mem_wdata;

    assign lo_avail = (r_lo != '0);
    assign hi_avail = (r_hi < r_cnt);

    // Read address for the current phase of work. The walk fetches the low
    // neighbor once and keeps it while high neighbors are taken.
    always_comb begin
        rd_en = i_cmd.rd_ins || i_cmd.rd_best || i_cmd.rd_walk;
        rd_addr = r_idx;
        if (i_cmd.rd_ins) begin
            rd_addr = r_pos - 1'b1;
        end else if (i_cmd.rd_walk) begin
            rd_addr = (lo_avail && !r_lok) ? r_lo - 1'b1 : r_hi;
        end
    end

    // Insertion walks down from the end, shifting each larger entry up.
    assign o_sts.ins_fin  = (r_pos == '0) || (r_rdata <= r_new);
    assign o_sts.cnt_zero = (r_cnt == '0);
    assign o_sts.best_fin = (r_idx + 1'b1 >= r_cnt);
    assign o_sts.walk_fin = !lo_avail && !hi_avail;
    assign o_sts.full     = (r_cnt >= CNT_MAX);

    always_comb begin
        mem_we = 1'b0;
        mem_waddr = r_pos[AW-1:0];
        mem_wdata = r_new;
        if (i_cmd.ins_step) begin
            mem_we = 1'b1;
            mem_wdata = r_rdata;
        end else if (i_cmd.ins_done) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr[AW-1:0]];
        end
    end

    logic [CYL_W-1:0] dl, dh, dn, nxt;
    logic take_low;
    always_comb begin
        dl = f_dist(r_lval, r_cur);
        dh = f_dist(r_rdata, r_cur);
        take_low = r_lok && (!hi_avail || dl < dh);
        nxt = take_low ? r_lval : r_rdata;
        dn = take_low ? dl : dh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_head  <= '0;
            r_lok   <= 1'b0;
            r_idx   <= '0;
            r_pos   <= '0;
            r_total <= '0;
        end else begin
            if (i_cfg_we) begin
                r_head <= f_clamp(i_cfg_data);
            end
            if (i_cmd.load) begin
                r_new <= f_clamp(i_req);
                r_idx <= '0;
                if (r_cnt >= CNT_MAX) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_pos <= r_cnt;
                end
            end
            if (i_cmd.ins_step) begin
                r_pos <= r_pos - 1'b1;
            end
            if (i_cmd.ins_done) begin
                r_cnt <= r_cnt + 1'b1;
                r_idx <= '0;
            end
            if (i_cmd.best_step) begin
                if (r_idx == '0 || f_dist(r_rdata, r_head) < r_bdist) begin
                    r_bdist <= f_dist(r_rdata, r_head);
                    r_lo    <= r_idx;
                    r_hi    <= r_idx + 1'b1;
                    r_cur   <= r_rdata;
                end
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.walk_init) begin
                r_total <= {{(MOVE_W+1-CYL_W){1'b0}},
                    ((r_idx == '0 || f_dist(r_rdata, r_head) < r_bdist) ?
                      f_dist(r_rdata, r_head) : r_bdist)};
                r_lok   <= 1'b0;
            end
            if (i_cmd.walk_step) begin
                if (!r_lok && lo_avail) begin
                    r_lval <= r_rdata;
                    r_lok  <= 1'b1;
                end else begin
                    r_cur <= nxt;
                    if (r_total[MOVE_W] == 1'b0) begin
                        r_total <= r_total + {{(MOVE_W+1-CYL_W){1'b0}}, dn};
                    end
                    if (take_low) begin
                        r_lo  <= r_lo - 1'b1;
                        r_lok <= 1'b0;
                    end else begin
                        r_hi <= r_hi + 1'b1;
                    end
                end
            end
            if (i_cmd.batch_clr) begin
                r_cnt <= '0;
                r_ovf <= 1'b0;
                r_total <= '0;
            end
        end
    end

    assign o_total = r_total[MOVE_W] ? MOVE_MAX : r_total[MOVE_W-1:0];
    assign o_ovf   = r_ovf;
endmodule
`default_nettype wire

// ===== tb/sstf_disk_schedule_movement_tb.sv =====
// Self-checking testbench for the SSTF disk scheduler (total head movement per batch).
// Depends on sds_pkg and the sstf_disk_schedule_movement RTL; reads nothing else.
`default_nettype none
module sstf_disk_schedule_movement_tb;
    import sds_pkg::*;

    localparam int unsigned STORE_DEPTH = 1024;
    localparam int unsigned IDLE_LIMIT  = 60000;

    typedef struct {
        logic [CYL_W-1:0] cylinder;
        logic             last;
    } t_request;

    typedef struct {
        logic [MOVE_W-1:0] movement;
        logic              dropped;
    } t_movement;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // [12:0] request_cylinder
    logic s_axis_tlast = 1'b0;        // is_last
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // [22:0] total_movement
    logic m_axis_tuser;               // overflowed
    logic i_cfg_we = 1'b0;
    logic [12:0] i_cfg_data = '0;

    sstf_disk_schedule_movement uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    t_request  pending_requests[$];
    t_movement expected_movements[$];
    int unsigned held_cylinders[$];
    logic [CYL_W-1:0] head_pos = '0;
    logic batch_dropped = 1'b0;
    int unsigned errors = 0;
    int unsigned idle_cycles = 0;

    function automatic int unsigned seek_dist(int unsigned a, int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Serves the held batch in SSTF order from the head and sums the seek distances.
    function automatic logic [MOVE_W-1:0] predict_seek_total();
        int unsigned n;
        int unsigned best;
        int unsigned cur;
        int unsigned below;
        int unsigned above;
        longint unsigned total;
        bit take_low;
        n = held_cylinders.size();
        if (n == 0) return '0;
        best = 0;
        for (int unsigned i = 1; i < n; i++)
            if (seek_dist(held_cylinders[i], head_pos) < seek_dist(held_cylinders[best], head_pos))
                best = i;
        total = seek_dist(held_cylinders[best], head_pos);
        cur = held_cylinders[best];
        below = best;
        above = best + 1;
        while (below > 0 || above < n) begin
            if (below == 0) take_low = 1'b0;
            else if (above >= n) take_low = 1'b1;
            else take_low = seek_dist(held_cylinders[below-1], cur)
                            < seek_dist(held_cylinders[above], cur);
            if (take_low) begin
                total += seek_dist(held_cylinders[below-1], cur);
                cur = held_cylinders[below-1];
                below--;
            end else begin
                total += seek_dist(held_cylinders[above], cur);
                cur = held_cylinders[above];
                above++;
            end
        end
        if (total > MOVE_MAX) total = MOVE_MAX;
        return total[MOVE_W-1:0];
    endfunction

    function automatic void accept_request(logic [CYL_W-1:0] cyl, logic last);
        int unsigned pos;
        t_movement res;
        if (held_cylinders.size() >= STORE_DEPTH) begin
            batch_dropped = 1'b1;
        end else begin
            pos = held_cylinders.size();
            while (pos > 0 && held_cylinders[pos-1] > cyl) pos--;
            held_cylinders.insert(pos, cyl);
        end
        if (last) begin
            res.movement = predict_seek_total();
            res.dropped = batch_dropped;
            expected_movements.push_back(res);
            held_cylinders.delete();
            batch_dropped = 1'b0;
        end
    endfunction

    // Sender: bursts of random length separated by random gaps.
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    always @(posedge i_clk) begin
        t_request req;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
                req = pending_requests.pop_front();
                s_axis_tdata <= {3'b000, req.cylinder};
                s_axis_tlast <= req.last;
                s_axis_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern: modes of random length, one of them never stalls.
    int unsigned stall_mode = 0;
    int unsigned mode_left = 0;
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(8, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Input accept updates the prediction; output accept checks it.
    always @(posedge i_clk) begin
        t_movement exp_res;
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            accept_request(s_axis_tdata[CYL_W-1:0], s_axis_tlast);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_movements.size() == 0) begin
                $display("%0t: expected no item, actual movement=%0d overflowed=%0b", $time,
                         m_axis_tdata[MOVE_W-1:0], m_axis_tuser);
                errors++;
            end else begin
                exp_res = expected_movements.pop_front();
                if (m_axis_tdata[MOVE_W-1:0] !== exp_res.movement) begin
                    $display("%0t: movement expected %0d actual %0d", $time,
                             exp_res.movement, m_axis_tdata[MOVE_W-1:0]);
                    errors++;
                end
                if (m_axis_tuser !== exp_res.dropped) begin
                    $display("%0t: overflowed expected %0b actual %0b", $time,
                             exp_res.dropped, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic add_request(int unsigned cyl, bit last);
        t_request req;
        req.cylinder = cyl[CYL_W-1:0];
        req.last = last;
        pending_requests.push_back(req);
    endtask

    // Waits for the block to drain, then writes the head start. The check runs
    // on the falling edge so that every update of the rising edge has settled.
    task automatic set_head(int unsigned head);
        while (pending_requests.size() > 0 || expected_movements.size() > 0 || s_axis_tvalid)
            @(negedge i_clk);
        repeat (30) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= head[CYL_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        head_pos = head[CYL_W-1:0];
    endtask

    task automatic add_random_batches(int unsigned count, int unsigned head);
        int unsigned size;
        int unsigned kind;
        int unsigned cyl;
        for (int unsigned b = 0; b < count; b++) begin
            size = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            kind = $urandom_range(0, 3);
            for (int unsigned i = 0; i < size; i++) begin
                case (kind)
                    0: cyl = $urandom_range(0, 8191);
                    1: cyl = (head + $urandom_range(0, 40) + 8192 - 20) % 8192;
                    2: cyl = $urandom_range(0, 3) * 2730;
                    default: cyl = ($urandom_range(0, 1)) ? $urandom_range(0, 15)
                                                           : $urandom_range(8176, 8191);
                endcase
                add_request(cyl, i == size - 1);
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, ties between neighbors, duplicates, single-item batches.
        add_request(0, 1);
        add_request(8191, 1);
        add_request(8191, 0); add_request(0, 0); add_request(8191, 1);
        set_head(100);
        add_request(110, 0); add_request(90, 0); add_request(200, 1);
        add_request(100, 0); add_request(100, 0); add_request(100, 1);
        add_request(95, 0); add_request(105, 0); add_request(0, 0); add_request(210, 1);
        set_head(8191);
        add_request(0, 0); add_request(8191, 0); add_request(4095, 1);
        add_request(5461, 0); add_request(2730, 1);

        // Store full: ascending keeps insertion cheap; the last two items are dropped.
        set_head(4096);
        for (int unsigned i = 0; i < STORE_DEPTH + 2; i++)
            add_request(i * 8, i == STORE_DEPTH + 1);
        add_request(7, 1);

        add_random_batches(35, 4096);
        set_head(0);
        add_random_batches(35, 0);
        set_head(8191);
        add_random_batches(35, 8191);
        begin
            int unsigned h;
            h = $urandom_range(0, 8191);
            set_head(h);
            add_random_batches(35, h);
        end

        while (pending_requests.size() > 0 || expected_movements.size() > 0 || s_axis_tvalid)
            @(negedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
